/* sv/mm_pkg.sv */
package mm_pkg;

    // Store geometry
    localparam int MAX_ROWS  = 8;
    localparam int MAX_INNER = 64;
    localparam int MAX_COLS  = 8;

    localparam int ROW_IDX_W   = $clog2(MAX_ROWS);
    localparam int INNER_IDX_W = $clog2(MAX_INNER);
    localparam int COL_IDX_W   = $clog2(MAX_COLS);
    localparam int A_ADDR_W    = ROW_IDX_W + INNER_IDX_W;
    localparam int B_ADDR_W    = INNER_IDX_W + COL_IDX_W;

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 16;
    localparam int OUT_POS_W = 3;
    localparam int SUM_W   = 32;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int ACC_W   = PROD_W + INNER_IDX_W;

    // Configuration registers
    localparam int ROWS_CFG_W  = 4;
    localparam int INNER_CFG_W = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_A_ROWS = 2'd0,
        CFG_A_COLS = 2'd1,
        CFG_B_ROWS = 2'd2,
        CFG_B_COLS = 2'd3
    } cfg_idx_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD_A  = 2'd0,
        FUNC_LOAD_B  = 2'd1,
        FUNC_COMPUTE = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_EMIT
    } state_t;

    // Control that travels with each operand pair into the MAC
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

/* sv/mm_if.sv */
interface mm_in_if;
    import mm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [FUNC_W-1:0]       func;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, func, row, col, value, input ready);
    modport sink   (input valid, func, row, col, value, output ready);
endinterface

interface mm_out_if;
    import mm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OUT_POS_W-1:0]    out_row;
    logic [OUT_POS_W-1:0]    out_col;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
    logic                    dim_error;

    modport source (output valid, out_row, out_col, sum, last, dim_error, input ready);
    modport sink   (input valid, out_row, out_col, sum, last, dim_error, output ready);
endinterface

/* sv/mm_mac.sv */
module mm_mac (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mm_pkg::mac_ctl_t                ctl,
    input  logic signed [mm_pkg::VAL_W-1:0] a,
    input  logic signed [mm_pkg::VAL_W-1:0] b,
    output logic                            done,
    output logic signed [mm_pkg::SUM_W-1:0] sum
);
    import mm_pkg::*;

    mac_ctl_t                 prod_ctl_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     done_reg;
    logic                     acc_pos;
    logic                     acc_neg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prod_ctl_reg <= '0;
            done_reg     <= 1'b0;
        end else begin
            prod_ctl_reg <= ctl;
            done_reg     <= prod_ctl_reg.vld && prod_ctl_reg.last;
        end
    end

    always_comb begin
        if (prod_ctl_reg.first) begin
            acc_next = ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk) begin
        if (ctl.vld) begin
            prod_reg <= a * b;
        end
        if (prod_ctl_reg.vld) begin
            acc_reg <= acc_next;
        end
    end

    // Saturate when the bits above the result width disagree with its sign
    assign acc_pos = !acc_reg[ACC_W-1] && (|acc_reg[ACC_W-2:SUM_W-1]);
    assign acc_neg = acc_reg[ACC_W-1] && !(&acc_reg[ACC_W-2:SUM_W-1]);

    always_comb begin
        if (acc_pos) begin
            sum = {1'b0, {(SUM_W-1){1'b1}}};
        end else if (acc_neg) begin
            sum = {1'b1, {(SUM_W-1){1'b0}}};
        end else begin
            sum = acc_reg[SUM_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

/* sv/matrix_multiply.sv */
// Fixed-point matrix multiply, C = A x B, elements signed Q8.8, sums Q16.16.
// item channel (sink): one beat per command. func load A / load B writes the
// element at (row, col) into its store; loads outside the configured
// dimensions are dropped. func compute runs the whole product.
// Unused func codes are consumed and ignored.
// result channel (source): one beat per C element in row-major order, last
// set on the final one. When the A column count differs from the B row count,
// compute returns a single beat with dim_error and last set and sum zero.
// Throughput: loads are taken one per cycle while the block is idle. A compute
// occupies the block until its final beat is emitted: one shared 16x16 multiplier
// with a 38-bit accumulator handles one product per cycle, fed from one read
// port on each store. item.ready stays low for the whole run.
// Elements are computed one after another; the sequencer waits for the MAC
// to finish each dot product before it emits that element's beat.
// The result register holds a beat while the receiver stalls; the sequencer
// waits at the next element until the beat is taken.
// Reset restores the dimension registers to 8 x 64 and 64 x 8 and clears the
// control state; the stores are not cleared and must be loaded before use.
// Configuration writes are taken at any cycle with cfg_we high; write only
// while the block is idle.
module matrix_multiply (
    input  logic                              clk,
    input  logic                              rst_n,
    mm_in_if.sink                             item,
    mm_out_if.source                          result,
    input  logic                              cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mm_pkg::*;

    // Dimension registers and their clamped counts
    logic [ROWS_CFG_W-1:0]  a_rows_reg;
    logic [INNER_CFG_W-1:0] a_cols_reg;
    logic [INNER_CFG_W-1:0] b_rows_reg;
    logic [ROWS_CFG_W-1:0]  b_cols_reg;
    logic [ROWS_CFG_W-1:0]  ar_cnt;
    logic [INNER_CFG_W-1:0] ac_cnt;
    logic [INNER_CFG_W-1:0] br_cnt;
    logic [ROWS_CFG_W-1:0]  bc_cnt;

    // Element stores
    logic [VAL_W-1:0] a_mem [2**A_ADDR_W];
    logic [VAL_W-1:0] b_mem [2**B_ADDR_W];
    logic signed [VAL_W-1:0] a_rd_reg;
    logic signed [VAL_W-1:0] b_rd_reg;

    // Sequencer
    state_t                 state_reg;
    state_t                 state_next;
    logic [ROW_IDX_W-1:0]   i_reg;
    logic [COL_IDX_W-1:0]   j_reg;
    logic [INNER_IDX_W-1:0] k_reg;
    logic                   err_reg;
    mac_ctl_t               iss_ctl_reg;

    // Result register
    logic                   out_vld_reg;
    logic [OUT_POS_W-1:0]   out_row_reg;
    logic [OUT_POS_W-1:0]   out_col_reg;
    logic signed [SUM_W-1:0] out_sum_reg;
    logic                   out_last_reg;
    logic                   out_err_reg;

    // Decoded controls
    logic     item_ready;
    logic     item_go;
    logic     load_a;
    logic     load_b;
    logic     start_run;
    logic     start_err;
    logic     issue;
    logic     k_last;
    logic     i_last;
    logic     j_last;
    logic     elem_last;
    logic     slot_free;
    logic     emit_go;
    logic     mac_done;
    logic signed [SUM_W-1:0] mac_sum;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            a_rows_reg <= ROWS_CFG_W'(MAX_ROWS);
            a_cols_reg <= INNER_CFG_W'(MAX_INNER);
            b_rows_reg <= INNER_CFG_W'(MAX_INNER);
            b_cols_reg <= ROWS_CFG_W'(MAX_COLS);
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_A_ROWS: a_rows_reg <= cfg_data[ROWS_CFG_W-1:0];
                CFG_A_COLS: a_cols_reg <= cfg_data[INNER_CFG_W-1:0];
                CFG_B_ROWS: b_rows_reg <= cfg_data[INNER_CFG_W-1:0];
                CFG_B_COLS: b_cols_reg <= cfg_data[ROWS_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp each dimension into its legal range; zero acts as one
    always_comb begin
        if (a_rows_reg == '0) begin
            ar_cnt = ROWS_CFG_W'(1);
        end else if (a_rows_reg > ROWS_CFG_W'(MAX_ROWS)) begin
            ar_cnt = ROWS_CFG_W'(MAX_ROWS);
        end else begin
            ar_cnt = a_rows_reg;
        end
        if (b_cols_reg == '0) begin
            bc_cnt = ROWS_CFG_W'(1);
        end else if (b_cols_reg > ROWS_CFG_W'(MAX_COLS)) begin
            bc_cnt = ROWS_CFG_W'(MAX_COLS);
        end else begin
            bc_cnt = b_cols_reg;
        end
        if (a_cols_reg == '0) begin
            ac_cnt = INNER_CFG_W'(1);
        end else if (a_cols_reg > INNER_CFG_W'(MAX_INNER)) begin
            ac_cnt = INNER_CFG_W'(MAX_INNER);
        end else begin
            ac_cnt = a_cols_reg;
        end
        if (b_rows_reg == '0) begin
            br_cnt = INNER_CFG_W'(1);
        end else if (b_rows_reg > INNER_CFG_W'(MAX_INNER)) begin
            br_cnt = INNER_CFG_W'(MAX_INNER);
        end else begin
            br_cnt = b_rows_reg;
        end
    end

    assign k_last    = {1'b0, k_reg} == (ac_cnt - INNER_CFG_W'(1));
    assign i_last    = {1'b0, i_reg} == (ar_cnt - ROWS_CFG_W'(1));
    assign j_last    = {1'b0, j_reg} == (bc_cnt - ROWS_CFG_W'(1));
    assign elem_last = i_last && j_last;
    assign slot_free = !out_vld_reg || result.ready;
    assign item_go   = item.valid && item_ready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start_err) begin
                    state_next = ST_EMIT;
                end else if (start_run) begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (k_last) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (mac_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    if (err_reg || elem_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_ISSUE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        item_ready = 1'b0;
        load_a     = 1'b0;
        load_b     = 1'b0;
        start_run  = 1'b0;
        start_err  = 1'b0;
        issue      = 1'b0;
        emit_go    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                item_ready = 1'b1;
                if (item.valid) begin
                    case (func_t'(item.func))
                        FUNC_LOAD_A: begin
                            load_a = (item.row < POS_W'(ar_cnt))
                                     && ({1'b0, item.col} < ac_cnt);
                        end
                        FUNC_LOAD_B: begin
                            load_b = ({1'b0, item.row} < br_cnt)
                                     && (item.col < POS_W'(bc_cnt));
                        end
                        FUNC_COMPUTE: begin
                            start_err = ac_cnt != br_cnt;
                            start_run = ac_cnt == br_cnt;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ISSUE: issue = 1'b1;
            ST_WAIT:  ;
            ST_EMIT:  emit_go = slot_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= ST_IDLE;
            i_reg       <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            err_reg     <= 1'b0;
            iss_ctl_reg <= '0;
        end else begin
            state_reg       <= state_next;
            iss_ctl_reg.vld   <= issue;
            iss_ctl_reg.first <= k_reg == '0;
            iss_ctl_reg.last  <= k_last;
            if (start_run || start_err) begin
                i_reg   <= '0;
                j_reg   <= '0;
                k_reg   <= '0;
                err_reg <= start_err;
            end
            if (issue) begin
                k_reg <= k_last ? '0 : k_reg + INNER_IDX_W'(1);
            end
            // Advance column inner, row outer
            if (emit_go && !err_reg && !elem_last) begin
                if (j_last) begin
                    j_reg <= '0;
                    i_reg <= i_reg + ROW_IDX_W'(1);
                end else begin
                    j_reg <= j_reg + COL_IDX_W'(1);
                end
            end
        end
    end

    // Store writes and registered reads
    always_ff @(posedge clk) begin
        if (item_go && load_a) begin
            a_mem[{item.row[ROW_IDX_W-1:0], item.col}] <= item.value;
        end
        a_rd_reg <= a_mem[{i_reg, k_reg}];
    end

    always_ff @(posedge clk) begin
        if (item_go && load_b) begin
            b_mem[{item.row, item.col[COL_IDX_W-1:0]}] <= item.value;
        end
        b_rd_reg <= b_mem[{k_reg, j_reg}];
    end

    mm_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (iss_ctl_reg),
        .a     (a_rd_reg),
        .b     (b_rd_reg),
        .done  (mac_done),
        .sum   (mac_sum)
    );

    // Result register: hold the beat until the receiver takes it
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_vld_reg <= 1'b0;
        end else if (emit_go) begin
            out_vld_reg <= 1'b1;
        end else if (result.ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (emit_go) begin
            out_row_reg  <= err_reg ? '0 : OUT_POS_W'(i_reg);
            out_col_reg  <= err_reg ? '0 : OUT_POS_W'(j_reg);
            out_sum_reg  <= err_reg ? '0 : mac_sum;
            out_last_reg <= err_reg || elem_last;
            out_err_reg  <= err_reg;
        end
    end

    assign item.ready       = item_ready;
    assign result.valid     = out_vld_reg;
    assign result.out_row   = out_row_reg;
    assign result.out_col   = out_col_reg;
    assign result.sum       = out_sum_reg;
    assign result.last      = out_last_reg;
    assign result.dim_error = out_err_reg;

`ifndef SYNTHESIS
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> state_reg == ST_WAIT)
        else $error("dot product finished outside the wait state");

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.dim_error) |-> result.last)
        else $error("dimension error beat without last");

    a_final_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_go && (err_reg || elem_last)) |=> state_reg == ST_IDLE)
        else $error("sequencer did not return to idle after final beat");

    a_no_issue_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) |-> !item.ready)
        else $error("item accepted while a dot product is issuing");
`endif

endmodule
